// ----- rtl/shape_overlap_test_assert.svh -----
// Assertion macros for the shape overlap pipeline.
// Each macro is a clocked check, off while rst_n is low.
`ifndef SHAPE_OVERLAP_TEST_ASSERT_SVH
`define SHAPE_OVERLAP_TEST_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define SOT_ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("shape_overlap_test: check failed");

// a in this cycle implies b in the next cycle
`define SOT_ASSERT_FOLLOW(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("shape_overlap_test: check failed");

`endif

// ----- rtl/sot_pkg.sv -----
package sot_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int RAD_BITS   = COORD_BITS - 2;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int PIPE_DEPTH = 4;

    localparam logic [1:0] KIND_BOX_BOX       = 2'd0;
    localparam logic [1:0] KIND_BOX_CIRCLE    = 2'd1;
    localparam logic [1:0] KIND_CIRCLE_CIRCLE = 2'd2;
    localparam logic [1:0] KIND_CIRCLE_BOX    = 2'd3;

    // all distances below are in doubled units
    typedef struct packed {
        logic [1:0]            kind;
        logic [COORD_BITS:0]   mag_x;
        logic [COORD_BITS:0]   mag_y;
        logic [COORD_BITS-1:0] ext_x;
        logic [COORD_BITS-1:0] ext_y;
        logic [SIZE_BITS-1:0]  in_x;
        logic [SIZE_BITS-1:0]  in_y;
        logic [COORD_BITS-1:0] rad2;
        logic                  corner_en;
    } front_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  in_range;
        logic                  corner_need;
        logic [COORD_BITS-1:0] off_x;
        logic [COORD_BITS-1:0] off_y;
        logic [COORD_BITS-1:0] rad2;
    } bound_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               in_range;
        logic               corner_need;
        logic [SQ_BITS-1:0] sq_x;
        logic [SQ_BITS-1:0] sq_y;
        logic [SQ_BITS-1:0] rsq;
    } square_t;

endpackage

// ----- rtl/sot_front.sv -----
module sot_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  self_x,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  self_y,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   self_width,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   self_height,
    input  logic        [sot_pkg::RAD_BITS-1:0]    self_radius,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  other_x,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  other_y,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   other_width,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   other_height,
    input  logic        [sot_pkg::RAD_BITS-1:0]    other_radius,
    output logic                                   out_valid,
    output sot_pkg::front_t                        out_word
);

    localparam int CB = sot_pkg::COORD_BITS;

    logic                 valid_reg;
    sot_pkg::front_t      front_reg;
    sot_pkg::front_t      front_next;
    logic [1:0]           kind;
    logic [CB:0]          diff_x;
    logic [CB:0]          diff_y;
    logic [CB:0]          neg_x;
    logic [CB:0]          neg_y;
    logic [CB-1:0]        abs_x;
    logic [CB-1:0]        abs_y;
    logic [CB-2:0]        rad_sum;

    always_comb
    begin
        if (self_radius == '0 && other_radius == '0)
            kind = sot_pkg::KIND_BOX_BOX;
        else if (self_radius == '0)
            kind = sot_pkg::KIND_BOX_CIRCLE;
        else if (other_radius != '0)
            kind = sot_pkg::KIND_CIRCLE_CIRCLE;
        else
            kind = sot_pkg::KIND_CIRCLE_BOX;
    end

    // distance is symmetric, so the centre offset does not depend on the pair kind
    assign diff_x = {self_x[CB-1], self_x} - {other_x[CB-1], other_x};
    assign diff_y = {self_y[CB-1], self_y} - {other_y[CB-1], other_y};
    assign neg_x  = (CB+1)'(0) - diff_x;
    assign neg_y  = (CB+1)'(0) - diff_y;
    assign abs_x  = diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
    assign abs_y  = diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];

    assign rad_sum = {1'b0, self_radius} + {1'b0, other_radius};

    always_comb
    begin
        front_next           = '0;
        front_next.kind      = kind;
        front_next.mag_x     = {abs_x, 1'b0};
        front_next.mag_y     = {abs_y, 1'b0};
        front_next.corner_en = (kind != sot_pkg::KIND_BOX_BOX);
        case (kind)
            sot_pkg::KIND_BOX_BOX:
            begin
                front_next.ext_x = {1'b0, self_width} + {1'b0, other_width};
                front_next.ext_y = {1'b0, self_height} + {1'b0, other_height};
            end
            sot_pkg::KIND_BOX_CIRCLE:
            begin
                front_next.in_x = self_width;
                front_next.in_y = self_height;
                front_next.rad2 = {1'b0, other_radius, 1'b0};
            end
            sot_pkg::KIND_CIRCLE_BOX:
            begin
                front_next.in_x = other_width;
                front_next.in_y = other_height;
                front_next.rad2 = {1'b0, self_radius, 1'b0};
            end
            default:
            begin
                front_next.rad2 = {rad_sum, 1'b0};
            end
        endcase
        // grow the inner box by the doubled radius
        if (kind != sot_pkg::KIND_BOX_BOX)
        begin
            front_next.ext_x = {1'b0, front_next.in_x} + front_next.rad2;
            front_next.ext_y = {1'b0, front_next.in_y} + front_next.rad2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = front_reg;

endmodule

// ----- rtl/sot_bound.sv -----
module sot_bound (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  sot_pkg::front_t in_word,
    output logic            out_valid,
    output sot_pkg::bound_t out_word
);

    localparam int CB = sot_pkg::COORD_BITS;

    logic            valid_reg;
    sot_pkg::bound_t bound_reg;
    sot_pkg::bound_t bound_next;
    logic [CB:0]     off_x_full;
    logic [CB:0]     off_y_full;

    // offset past the inner box edge; fits CB bits whenever the range test passes
    assign off_x_full = in_word.mag_x - {2'b00, in_word.in_x};
    assign off_y_full = in_word.mag_y - {2'b00, in_word.in_y};

    always_comb
    begin
        bound_next.kind        = in_word.kind;
        bound_next.in_range    = (in_word.mag_x < {1'b0, in_word.ext_x})
                              && (in_word.mag_y < {1'b0, in_word.ext_y});
        bound_next.corner_need = in_word.corner_en
                              && (in_word.mag_x > {2'b00, in_word.in_x})
                              && (in_word.mag_y > {2'b00, in_word.in_y});
        bound_next.off_x       = off_x_full[CB-1:0];
        bound_next.off_y       = off_y_full[CB-1:0];
        bound_next.rad2        = in_word.rad2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = bound_reg;

endmodule

// ----- rtl/sot_square.sv -----
module sot_square (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  sot_pkg::bound_t  in_word,
    output logic             out_valid,
    output sot_pkg::square_t out_word
);

    localparam int SQ = sot_pkg::SQ_BITS;

    logic             valid_reg;
    sot_pkg::square_t square_reg;
    sot_pkg::square_t square_next;

    always_comb
    begin
        square_next.kind        = in_word.kind;
        square_next.in_range    = in_word.in_range;
        square_next.corner_need = in_word.corner_need;
        square_next.sq_x        = SQ'(in_word.off_x) * SQ'(in_word.off_x);
        square_next.sq_y        = SQ'(in_word.off_y) * SQ'(in_word.off_y);
        square_next.rsq         = SQ'(in_word.rad2) * SQ'(in_word.rad2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        square_reg <= square_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = square_reg;

endmodule

// ----- rtl/shape_overlap_test.sv -----
// Overlap test for one pair of 2D shapes (box when the radius is zero, circle
// otherwise) with Q12.4 coordinates. A pair is taken on every cycle that start
// is high; busy never rises. The word for a pair appears on hit and pair_kind
// with done high for one cycle once it has passed through every register stage, in the
// order the pairs went in, at one pair per cycle sustained. The four register
// stages are offset and extent selection, range and corner test, squaring, and
// the final sum and compare. There is no back-pressure: the receiver must take
// every word in the cycle that done is high.
`include "shape_overlap_test_assert.svh"

module shape_overlap_test (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  self_x,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  self_y,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   self_width,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   self_height,
    input  logic        [sot_pkg::RAD_BITS-1:0]    self_radius,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  other_x,
    input  logic signed [sot_pkg::COORD_BITS-1:0]  other_y,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   other_width,
    input  logic        [sot_pkg::SIZE_BITS-1:0]   other_height,
    input  logic        [sot_pkg::RAD_BITS-1:0]    other_radius,
    output logic                                   done,
    output logic                                   hit,
    output logic        [1:0]                      pair_kind
);

    localparam int SQ = sot_pkg::SQ_BITS;

    logic             front_valid;
    sot_pkg::front_t  front_word;
    logic             bound_valid;
    sot_pkg::bound_t  bound_word;
    logic             square_valid;
    sot_pkg::square_t square_word;
    logic [SQ:0]      dist_sum;
    logic             done_reg;
    logic             hit_reg;
    logic             hit_next;
    logic [1:0]       kind_reg;
    logic             bound_box_box;
    logic             square_outside;

    assign busy = 1'b0;

    sot_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .self_x       (self_x),
        .self_y       (self_y),
        .self_width   (self_width),
        .self_height  (self_height),
        .self_radius  (self_radius),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_width  (other_width),
        .other_height (other_height),
        .other_radius (other_radius),
        .out_valid    (front_valid),
        .out_word     (front_word)
    );

    sot_bound u_bound (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_word   (front_word),
        .out_valid (bound_valid),
        .out_word  (bound_word)
    );

    sot_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bound_valid),
        .in_word   (bound_word),
        .out_valid (square_valid),
        .out_word  (square_word)
    );

    assign dist_sum = {1'b0, square_word.sq_x} + {1'b0, square_word.sq_y};

    // inside the grown box counts, but in a corner region only within the radius
    assign hit_next = square_word.in_range
                   && (!square_word.corner_need || (dist_sum < {1'b0, square_word.rsq}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= square_valid;
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        kind_reg <= square_word.kind;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign pair_kind = kind_reg;

    assign bound_box_box  = bound_valid && bound_word.kind == sot_pkg::KIND_BOX_BOX;
    assign square_outside = square_valid && square_word.corner_need && !square_word.in_range;

    `SOT_ASSERT_IMPLY(a_done_latency, done, $past(start && !busy, sot_pkg::PIPE_DEPTH))
    `SOT_ASSERT_FOLLOW(a_square_to_done, square_valid, done)
    `SOT_ASSERT_IMPLY(a_box_box_no_corner, bound_box_box, !bound_word.corner_need)
    `SOT_ASSERT_IMPLY(a_corner_needs_range, square_outside, !hit_next)

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB            = sot_pkg::COORD_BITS;
    localparam int SB            = sot_pkg::SIZE_BITS;
    localparam int RB            = sot_pkg::RAD_BITS;
    localparam int RANDOM_PAIRS  = 1450;
    localparam int DIRECTED_ROWS = 23;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct {
        logic signed [CB-1:0] self_x;
        logic signed [CB-1:0] self_y;
        logic        [SB-1:0] self_width;
        logic        [SB-1:0] self_height;
        logic        [RB-1:0] self_radius;
        logic signed [CB-1:0] other_x;
        logic signed [CB-1:0] other_y;
        logic        [SB-1:0] other_width;
        logic        [SB-1:0] other_height;
        logic        [RB-1:0] other_radius;
    } shape_pair_t;

    typedef struct {
        logic       hit;
        logic [1:0] kind;
    } overlap_word_t;

    typedef struct {
        shape_pair_t   pair;
        bit            known;
        overlap_word_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic        hit;
    logic [1:0]  pair_kind;
    shape_pair_t drive_pair = '{default: '0};

    overlap_word_t awaited[$];
    int          mismatches = 0;
    int          cycle_count = 0;

    // rows flagged known carry the answer; the rest go through predict_overlap
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, sot_pkg::KIND_BOX_BOX}},
        '{'{0, 0, 32, 32, 0, 8, 8, 32, 32, 0}, 1, '{1, sot_pkg::KIND_BOX_BOX}},
        '{'{0, 0, 32, 32, 0, 32, 0, 32, 32, 0}, 1, '{0, sot_pkg::KIND_BOX_BOX}},
        '{'{-32768, -32768, 32767, 32767, 0, 32767, 32767, 32767, 32767, 0},
          1, '{0, sot_pkg::KIND_BOX_BOX}},
        '{'{-32768, -32768, 32767, 32767, 0, -32768, -32768, 32767, 32767, 0},
          1, '{1, sot_pkg::KIND_BOX_BOX}},
        '{'{0, 0, 0, 0, 0, 0, 0, 2, 2, 0}, 0, '{0, sot_pkg::KIND_BOX_BOX}},
        '{'{0, 0, 32, 32, 0, 0, 0, 0, 0, 16}, 1, '{1, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32, 32, 0, 32767, 32767, 32767, 32767, 1},
          1, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32, 32, 0, -20, -20, 0, 0, 8}, 0, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32, 32, 0, -20, 20, 0, 0, 5}, 0, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32, 32, 0, 20, -20, 0, 0, 5}, 0, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32, 32, 0, 20, 20, 0, 0, 8}, 0, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32, 32, 0, 24, 0, 0, 0, 8}, 0, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 0, 0, 16, 32, 0, 0, 0, 16}, 1, '{0, sot_pkg::KIND_CIRCLE_CIRCLE}},
        '{'{0, 0, 0, 0, 16, 31, 0, 0, 0, 16}, 0, '{0, sot_pkg::KIND_CIRCLE_CIRCLE}},
        '{'{-32768, -32768, 0, 0, 16383, 32767, 32767, 0, 0, 16383},
          1, '{0, sot_pkg::KIND_CIRCLE_CIRCLE}},
        '{'{32767, -32768, 0, 0, 16383, 32767, -32768, 0, 0, 16383},
          1, '{1, sot_pkg::KIND_CIRCLE_CIRCLE}},
        '{'{0, 0, 0, 0, 16, 0, 0, 32, 32, 0}, 1, '{1, sot_pkg::KIND_CIRCLE_BOX}},
        '{'{32767, 32767, 0, 0, 16383, -32768, -32768, 32767, 32767, 0},
          0, '{0, sot_pkg::KIND_CIRCLE_BOX}},
        '{'{-20, -20, 0, 0, 8, 0, 0, 32, 32, 0}, 0, '{0, sot_pkg::KIND_CIRCLE_BOX}},
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 1}, 0, '{0, sot_pkg::KIND_BOX_CIRCLE}},
        '{'{0, 0, 32767, 32767, 1, 0, 0, 32767, 32767, 0},
          0, '{0, sot_pkg::KIND_CIRCLE_BOX}},
        '{'{0, 0, 0, 0, 1, 1, 1, 0, 0, 1}, 0, '{0, sot_pkg::KIND_CIRCLE_CIRCLE}}
    };

    shape_overlap_test DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .self_x       (drive_pair.self_x),
        .self_y       (drive_pair.self_y),
        .self_width   (drive_pair.self_width),
        .self_height  (drive_pair.self_height),
        .self_radius  (drive_pair.self_radius),
        .other_x      (drive_pair.other_x),
        .other_y      (drive_pair.other_y),
        .other_width  (drive_pair.other_width),
        .other_height (drive_pair.other_height),
        .other_radius (drive_pair.other_radius),
        .done         (done),
        .hit          (hit),
        .pair_kind    (pair_kind)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // all lengths in doubled units so that half sizes stay whole
    function automatic bit box_circle_hit(input longint bx, input longint by,
                                          input longint bw, input longint bh,
                                          input longint cx, input longint cy,
                                          input longint r);
        longint left, right, down, up, px, py, rr, kx, ky;
        left  = 2 * bx - bw;
        right = 2 * bx + bw;
        down  = 2 * by - bh;
        up    = 2 * by + bh;
        px    = 2 * cx;
        py    = 2 * cy;
        rr    = 2 * r;
        if (!(px > left - rr && px < right + rr && py > down - rr && py < up + rr))
            return 1'b0;
        if (px < left)
            kx = left;
        else if (px > right)
            kx = right;
        else
            return 1'b1;
        if (py < down)
            ky = down;
        else if (py > up)
            ky = up;
        else
            return 1'b1;
        return (px - kx) * (px - kx) + (py - ky) * (py - ky) < rr * rr;
    endfunction

    function automatic overlap_word_t predict_overlap(input shape_pair_t p);
        overlap_word_t w;
        longint sx, sy, sw, sh, sr, ox, oy, ow, oh, orad, reach, dx, dy;
        sx   = longint'(p.self_x);
        sy   = longint'(p.self_y);
        sw   = longint'(p.self_width);
        sh   = longint'(p.self_height);
        sr   = longint'(p.self_radius);
        ox   = longint'(p.other_x);
        oy   = longint'(p.other_y);
        ow   = longint'(p.other_width);
        oh   = longint'(p.other_height);
        orad = longint'(p.other_radius);
        if (sr == 0 && orad == 0)
        begin
            w.kind = sot_pkg::KIND_BOX_BOX;
            w.hit  = (2 * sx - sw < 2 * ox + ow) && (2 * ox - ow < 2 * sx + sw) &&
                     (2 * sy - sh < 2 * oy + oh) && (2 * oy - oh < 2 * sy + sh);
        end
        else if (sr == 0)
        begin
            w.kind = sot_pkg::KIND_BOX_CIRCLE;
            w.hit  = box_circle_hit(sx, sy, sw, sh, ox, oy, orad);
        end
        else if (orad != 0)
        begin
            w.kind = sot_pkg::KIND_CIRCLE_CIRCLE;
            reach  = sr + orad;
            dx     = sx - ox;
            dy     = sy - oy;
            if (dx >= reach || -dx >= reach || dy >= reach || -dy >= reach)
                w.hit = 1'b0;
            else
                w.hit = dx * dx + dy * dy < reach * reach;
        end
        else
        begin
            w.kind = sot_pkg::KIND_CIRCLE_BOX;
            w.hit  = box_circle_hit(ox, oy, ow, oh, sx, sy, sr);
        end
        return w;
    endfunction

    // mostly pairs close together so that hits and corner regions turn up;
    // a quarter are drawn over the full field ranges
    function automatic shape_pair_t random_pair();
        shape_pair_t p;
        int spread;
        if ($urandom_range(0, 3) == 0)
        begin
            p.self_x       = CB'($urandom);
            p.self_y       = CB'($urandom);
            p.self_width   = SB'($urandom);
            p.self_height  = SB'($urandom);
            p.self_radius  = $urandom_range(0, 1) ? '0 : RB'($urandom);
            p.other_x      = CB'($urandom);
            p.other_y      = CB'($urandom);
            p.other_width  = SB'($urandom);
            p.other_height = SB'($urandom);
            p.other_radius = $urandom_range(0, 1) ? '0 : RB'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: spread = 16;
                1: spread = 256;
                2: spread = 2048;
                default: spread = 8192;
            endcase
            p.self_x       = CB'($urandom);
            p.self_y       = CB'($urandom);
            p.other_x      = CB'(p.self_x + $urandom_range(0, 4 * spread) - 2 * spread);
            p.other_y      = CB'(p.self_y + $urandom_range(0, 4 * spread) - 2 * spread);
            p.self_width   = SB'($urandom_range(0, 2 * spread));
            p.self_height  = SB'($urandom_range(0, 2 * spread));
            p.other_width  = SB'($urandom_range(0, 2 * spread));
            p.other_height = SB'($urandom_range(0, 2 * spread));
            p.self_radius  = $urandom_range(0, 1) ? '0 : RB'($urandom_range(1, spread));
            p.other_radius = $urandom_range(0, 1) ? '0 : RB'($urandom_range(1, spread));
        end
        return p;
    endfunction

    // hold the word on the ports until it is taken, then log its answer
    task automatic send_pair(input shape_pair_t p, input overlap_word_t want);
        start      <= 1'b1;
        drive_pair <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        awaited.push_back(want);
    endtask

    task automatic idle_for(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap(input int index);
        int roll;
        // leave stretches of back-to-back words
        if (index % 200 < 40)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        overlap_word_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: hit=%0b pair_kind=%0d",
                       hit, pair_kind);
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0b, actual %0b", want.hit, hit);
                    mismatches++;
                end
                if (pair_kind !== want.kind)
                begin
                    $error("pair_kind: expected %0d, actual %0d", want.kind, pair_kind);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        shape_pair_t p;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
                send_pair(directed_rows[i].pair, directed_rows[i].want);
            else
                send_pair(directed_rows[i].pair, predict_overlap(directed_rows[i].pair));
            idle_for($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        end
        drain_results();

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            p = random_pair();
            send_pair(p, predict_overlap(p));
            if (i == RANDOM_PAIRS / 2)
                drain_results();
            else
                idle_for(pick_gap(i));
        end

        drain_results();
        repeat (sot_pkg::PIPE_DEPTH + 8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
